/* sv/itrf_pkg.sv */
// Shared types, constants and helpers for the I2C target register bank.
// No dependencies; every other file of the block imports this package.
package itrf_pkg;

	localparam int BANK_DEPTH = 256;
	localparam int AW = $clog2(BANK_DEPTH);
	localparam int RO_REGS = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// item kinds
	localparam logic [2:0] OP_RECV   = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_STOP   = 3'd2;
	localparam logic [2:0] OP_TICK   = 3'd3;
	localparam logic [2:0] OP_LWRITE = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RO_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IN2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ2    = 3'd4;

	localparam logic [31:0] RST_RO_MASK = 32'hFFE4_FBC5;
	localparam logic [7:0]  RST_IN1     = 8'd6;
	localparam logic [7:0]  RST_IN2     = 8'd7;
	localparam logic [7:0]  RST_IRQ1    = 8'd8;
	localparam logic [7:0]  RST_IRQ2    = 8'd9;

	typedef struct packed {
		logic [31:0] ro_mask;
		logic [7:0]  in1_addr;
		logic [7:0]  in2_addr;
		logic [7:0]  irq1_addr;
		logic [7:0]  irq2_addr;
	} cfg_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic [7:0] local_reg;
		logic       sample_valid;
		logic [7:0] input1_sample;
		logic [4:0] input2_sample;
		logic       raise_request;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       write_valid;
		logic [7:0] write_reg;
		logic [7:0] write_value;
		logic       irq_line_active;
	} result_t;

	function automatic logic in_bank(input logic [7:0] a);
		return {1'b0, a} < 9'(BANK_DEPTH);
	endfunction

	function automatic logic [AW-1:0] bank_idx(input logic [7:0] a);
		return a[AW-1:0];
	endfunction

	function automatic logic is_readonly(input logic [31:0] mask, input logic [7:0] a);
		return (a < 8'(RO_REGS)) && mask[a[4:0]];
	endfunction

endpackage

/* sv/i2c_target_register_file_unit.sv */
// I2C target register bank, top level. Items enter on the s_ stream, one
// result leaves on the m_ stream for every item. After reset the 256-entry
// bank is swept to zero, one entry per cycle; s_tready stays low during that
// pass while configuration writes are taken as usual. Items are handled one
// at a time. Bus receive, bus stop, local write, unused kinds and a service
// tick without a sample go straight to the result step; a bus read waits for
// the registered read data, then clears both sticky registers if it read the
// second one; a service tick with a button sample reads button 1, updates
// sticky 1, writes button 1, then does the same for button 2 and sticky 2.
// Each step is a separate read or write on the bank, a single memory with one
// write and one registered read per cycle. A finished result sits in the
// output register, and the next item is accepted while it waits; only the end
// of that item then waits for the sink. Configuration is written on cfg_we
// with cfg_index 0..4 (read-only mask, button 1, button 2, sticky 1, sticky 2
// addresses); other indexes are ignored.
// Depends on itrf_pkg, itrf_cfg, itrf_bank and itrf_seq.
module i2c_target_register_file_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] data_byte, [15:8] local_reg, [16] sample_valid,
	// [24:17] input1_sample, [29:25] input2_sample, [30] raise_request, [31] zero
	input  logic [31:0]                     s_tdata,
	// [2:0] opcode
	input  logic [2:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_data, [15:8] write_reg, [23:16] write_value,
	// [24] irq_line_active, [31:25] zero
	output logic [31:0]                     m_tdata,
	// [0] write_valid
	output logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [itrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import itrf_pkg::*;

	cfg_t     cfg;
	item_t    item;
	result_t  res;
	mem_req_t req;
	logic [7:0] rdata;

	// unpack the incoming transfer
	assign item.opcode        = s_tuser;
	assign item.data_byte     = s_tdata[7:0];
	assign item.local_reg     = s_tdata[15:8];
	assign item.sample_valid  = s_tdata[16];
	assign item.input1_sample = s_tdata[24:17];
	assign item.input2_sample = s_tdata[29:25];
	assign item.raise_request = s_tdata[30];

	// pack the outgoing transfer
	assign m_tdata = {7'd0, res.irq_line_active, res.write_value, res.write_reg,
		res.read_data};
	assign m_tuser = res.write_valid;

	itrf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	itrf_bank u_bank (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	itrf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item     (item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res),
		.req      (req),
		.rdata    (rdata)
	);

endmodule

/* sv/itrf_bank.sv */
// Register bank storage: single write port, single read port, registered read.
// Depends on itrf_pkg for depth and request type.
module itrf_bank (
	input  logic               clk,
	input  itrf_pkg::mem_req_t req,
	output logic [7:0]         rdata
);
	import itrf_pkg::*;

	logic [7:0] mem [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

/* sv/itrf_cfg.sv */
// Configuration registers: read-only mask and the four special addresses.
// Depends on itrf_pkg.
module itrf_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output itrf_pkg::cfg_t                 cfg
);
	import itrf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ro_mask   <= RST_RO_MASK;
			cfg_q.in1_addr  <= RST_IN1;
			cfg_q.in2_addr  <= RST_IN2;
			cfg_q.irq1_addr <= RST_IRQ1;
			cfg_q.irq2_addr <= RST_IRQ2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RO_MASK: cfg_q.ro_mask   <= cfg_wdata;
				CFG_IN1:     cfg_q.in1_addr  <= cfg_wdata[7:0];
				CFG_IN2:     cfg_q.in2_addr  <= cfg_wdata[7:0];
				CFG_IRQ1:    cfg_q.irq1_addr <= cfg_wdata[7:0];
				CFG_IRQ2:    cfg_q.irq2_addr <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/itrf_seq.sv */
// Item sequencer: pointer and interrupt state, read-modify-write steps on the
// bank, clearing pass after reset, and the result register. Depends on itrf_pkg.
module itrf_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  itrf_pkg::cfg_t      cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  itrf_pkg::item_t     item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output itrf_pkg::result_t   res,
	output itrf_pkg::mem_req_t  req,
	input  logic [7:0]          rdata
);
	import itrf_pkg::*;

	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_RD_WAIT   = 4'd2;
	localparam logic [3:0] ST_CLR_IRQ1  = 4'd3;
	localparam logic [3:0] ST_CLR_IRQ2  = 4'd4;
	localparam logic [3:0] ST_S_RD_IRQ1 = 4'd5;
	localparam logic [3:0] ST_S_WR_IRQ1 = 4'd6;
	localparam logic [3:0] ST_S_WR_IN1  = 4'd7;
	localparam logic [3:0] ST_S_RD_IN2  = 4'd8;
	localparam logic [3:0] ST_S_RD_IRQ2 = 4'd9;
	localparam logic [3:0] ST_S_WR_IRQ2 = 4'd10;
	localparam logic [3:0] ST_S_WR_IN2  = 4'd11;
	localparam logic [3:0] ST_DONE      = 4'd12;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    ptr_q;
	logic [7:0]    rptr_q;
	logic          write_active_q;
	logic          irq_target_q;
	logic          irq_state_q;
	logic          irq_clear_pending_q;
	logic          hit_q;
	logic [7:0]    s1_q;
	logic [4:0]    s2_q;
	logic [7:0]    old_q;
	logic [7:0]    rd_q;
	logic          wv_q;
	logic [7:0]    wreg_q;
	logic [7:0]    wval_q;
	logic          m_tvalid_q;
	result_t       res_q;

	logic          accept;
	logic [7:0]    s2_ext;
	logic [7:0]    old1_v;
	logic [7:0]    old2_v;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign s2_ext   = {3'b000, s2_q};
	assign old1_v   = in_bank(cfg.in1_addr) ? rdata : 8'd0;
	assign old2_v   = in_bank(cfg.in2_addr) ? rdata : 8'd0;
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	// bank port requests
	always_comb begin
		req       = '0;
		req.raddr = bank_idx(ptr_q);
		case (state_q)
			ST_CLEAR: begin
				req.we    = 1'b1;
				req.waddr = clr_q;
				req.wdata = 8'd0;
			end
			ST_IDLE: begin
				if (accept) begin
					case (item.opcode)
						OP_RECV: begin
							req.we    = write_active_q && !is_readonly(cfg.ro_mask, ptr_q)
								&& in_bank(ptr_q);
							req.waddr = bank_idx(ptr_q);
							req.wdata = item.data_byte;
						end
						OP_LWRITE: begin
							req.we    = in_bank(item.local_reg);
							req.waddr = bank_idx(item.local_reg);
							req.wdata = item.data_byte;
						end
						OP_TICK: req.raddr = bank_idx(cfg.in1_addr);
						default: ;
					endcase
				end
			end
			ST_CLR_IRQ1: begin
				req.we    = in_bank(cfg.irq1_addr);
				req.waddr = bank_idx(cfg.irq1_addr);
				req.wdata = 8'd0;
			end
			ST_CLR_IRQ2: begin
				req.we    = in_bank(cfg.irq2_addr);
				req.waddr = bank_idx(cfg.irq2_addr);
				req.wdata = 8'd0;
			end
			ST_S_RD_IRQ1: req.raddr = bank_idx(cfg.irq1_addr);
			ST_S_WR_IRQ1: begin
				req.we    = in_bank(cfg.irq1_addr);
				req.waddr = bank_idx(cfg.irq1_addr);
				req.wdata = rdata | (s1_q ^ old_q);
			end
			ST_S_WR_IN1: begin
				req.we    = in_bank(cfg.in1_addr);
				req.waddr = bank_idx(cfg.in1_addr);
				req.wdata = s1_q;
			end
			ST_S_RD_IN2:  req.raddr = bank_idx(cfg.in2_addr);
			ST_S_RD_IRQ2: req.raddr = bank_idx(cfg.irq2_addr);
			ST_S_WR_IRQ2: begin
				req.we    = in_bank(cfg.irq2_addr);
				req.waddr = bank_idx(cfg.irq2_addr);
				req.wdata = rdata | (s2_ext ^ old_q);
			end
			ST_S_WR_IN2: begin
				req.we    = in_bank(cfg.in2_addr);
				req.waddr = bank_idx(cfg.in2_addr);
				req.wdata = s2_ext;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_CLEAR;
			clr_q               <= '0;
			ptr_q               <= 8'd0;
			rptr_q              <= 8'd0;
			write_active_q      <= 1'b0;
			irq_target_q        <= 1'b0;
			irq_state_q         <= 1'b0;
			irq_clear_pending_q <= 1'b0;
			hit_q               <= 1'b0;
			s1_q                <= 8'd0;
			s2_q                <= 5'd0;
			old_q               <= 8'd0;
			rd_q                <= 8'd0;
			wv_q                <= 1'b0;
			wreg_q              <= 8'd0;
			wval_q              <= 8'd0;
			m_tvalid_q          <= 1'b0;
			res_q               <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(BANK_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_q    <= 8'd0;
						wv_q    <= 1'b0;
						wreg_q  <= 8'd0;
						wval_q  <= 8'd0;
						s1_q    <= item.input1_sample;
						s2_q    <= item.input2_sample;
						state_q <= ST_DONE;
						case (item.opcode)
							OP_RECV: begin
								if (!write_active_q) begin
									ptr_q          <= item.data_byte;
									write_active_q <= 1'b1;
								end else begin
									if (!is_readonly(cfg.ro_mask, ptr_q) && in_bank(ptr_q)) begin
										wv_q   <= 1'b1;
										wreg_q <= ptr_q;
										wval_q <= item.data_byte;
									end
									ptr_q <= ptr_q + 8'd1;
								end
							end
							OP_READ: begin
								write_active_q <= 1'b0;
								rptr_q         <= ptr_q;
								ptr_q          <= ptr_q + 8'd1;
								hit_q          <= (ptr_q == cfg.irq2_addr);
								if (ptr_q == cfg.irq2_addr) begin
									irq_target_q        <= 1'b0;
									irq_clear_pending_q <= 1'b1;
								end
								state_q <= ST_RD_WAIT;
							end
							OP_STOP: write_active_q <= 1'b0;
							OP_TICK: begin
								// line first, then raise, then the button sample
								if (irq_clear_pending_q) begin
									irq_state_q         <= 1'b0;
									irq_clear_pending_q <= 1'b0;
								end else begin
									irq_state_q <= irq_target_q;
								end
								if (item.raise_request) begin
									irq_target_q <= 1'b1;
								end
								if (item.sample_valid) begin
									state_q <= ST_S_RD_IRQ1;
								end
							end
							OP_LWRITE: begin
								if (in_bank(item.local_reg)) begin
									wv_q   <= 1'b1;
									wreg_q <= item.local_reg;
									wval_q <= item.data_byte;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD_WAIT: begin
					rd_q    <= in_bank(rptr_q) ? rdata : 8'd0;
					state_q <= hit_q ? ST_CLR_IRQ1 : ST_DONE;
				end
				ST_CLR_IRQ1: state_q <= ST_CLR_IRQ2;
				ST_CLR_IRQ2: state_q <= ST_DONE;
				ST_S_RD_IRQ1: begin
					old_q <= old1_v;
					if (s1_q != old1_v) begin
						irq_target_q <= 1'b1;
					end
					state_q <= ST_S_WR_IRQ1;
				end
				ST_S_WR_IRQ1: state_q <= ST_S_WR_IN1;
				ST_S_WR_IN1:  state_q <= ST_S_RD_IN2;
				ST_S_RD_IN2:  state_q <= ST_S_RD_IRQ2;
				ST_S_RD_IRQ2: begin
					old_q <= old2_v;
					if (s2_ext != old2_v) begin
						irq_target_q <= 1'b1;
					end
					state_q <= ST_S_WR_IRQ2;
				end
				ST_S_WR_IRQ2: state_q <= ST_S_WR_IN2;
				ST_S_WR_IN2:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q            <= 1'b1;
						res_q.read_data       <= rd_q;
						res_q.write_valid     <= wv_q;
						res_q.write_reg       <= wreg_q;
						res_q.write_value     <= wval_q;
						res_q.irq_line_active <= irq_state_q;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_pending_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		irq_clear_pending_q |-> !irq_target_q)
		else $error("clear pending while interrupt target raised");

	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.write_valid |-> res.read_data == 8'd0)
		else $error("result reports a write and read data together");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !m_tvalid)
		else $error("result offered during clearing pass");
`endif

endmodule
